// ----- hdl/sst_pkg.sv -----
package sst_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 5;
  localparam int unsigned CountW = 6;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Broadcast to every cell in the commit cycle
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [ValueW-1:0] key;
  } cell_ctrl_t;

endpackage

// ----- hdl/sst_cell.sv -----
module sst_cell (
  input  logic                              clk_i,
  input  logic                              capture_i,
  input  logic signed [sst_pkg::ValueW-1:0] cmp_key_i,
  input  logic                              valid_i,
  input  sst_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              prev_ge_i,
  input  logic signed [sst_pkg::ValueW-1:0] prev_val_i,
  input  logic signed [sst_pkg::ValueW-1:0] next_val_i,
  output logic                              ge_o,
  output logic                              hit_o,
  output logic signed [sst_pkg::ValueW-1:0] val_o
);
  import sst_pkg::*;

  logic signed [ValueW-1:0] val_q, val_d;
  logic                     ge_q, eq_q;

  // Empty slots count as greater than any key so the flags form a thermometer
  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      ge_q <= !valid_i || (val_q >= cmp_key_i);
      eq_q <= valid_i && (val_q == cmp_key_i);
    end
  end

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (prev_ge_i) begin
        val_d = prev_val_i;
      end else if (ge_q) begin
        val_d = ctrl_i.key;
      end
    end else if (ctrl_i.del && ge_q) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign ge_o  = ge_q;
  assign hit_o = ge_q && !prev_ge_i && eq_q;
  assign val_o = val_q;

endmodule

// ----- hdl/sst_encoder.sv -----
module sst_encoder #(
  parameter int unsigned Depth = 32,
  parameter int unsigned IdxW  = 5
) (
  input  logic [Depth-1:0] hit_i,
  output logic [IdxW-1:0]  idx_o,
  output logic             found_o
);

  // At most one cell hits, so an OR of the selected indices encodes it
  always_comb begin
    idx_o = '0;
    for (int unsigned j = 0; j < Depth; j++) begin
      idx_o = idx_o | (IdxW'(j) & {IdxW{hit_i[j]}});
    end
  end

  assign found_o = |hit_i;

endmodule

// ----- hdl/sorted_set_table.sv -----
// At accept every cell latches its compare; at commit the table encodes the first match,
// registers the result and, for an insert or delete, shifts the cell chain by one place.
// A new transaction is accepted only after the previous one has committed.
// A result waiting on out_ready_i holds the commit and the table update with it.
// Reset clears the entry count and the handshake state; cell values are not cleared.
module sorted_set_table #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [sst_pkg::ValueW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [sst_pkg::PosW-1:0]          position_o,
  output logic [sst_pkg::CountW-1:0]        count_o
);
  import sst_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                     busy_q;
  logic [1:0]               cmd_q;
  logic signed [ValueW-1:0] key_q;
  logic [CntW-1:0]          count_q, count_d;
  logic                     out_valid_q;
  logic [1:0]               status_q, status_d;
  logic [PosW-1:0]          position_q, position_d;
  logic [CountW-1:0]        res_count_q;

  logic                     accept, commit, full, empty, found;
  logic [IdxW-1:0]          hit_idx;
  logic [IdxW+PosW-1:0]     idx_ext;
  logic [CntW+CountW-1:0]   cnt_ext;
  cell_ctrl_t               ctrl;

  logic [CAPACITY-1:0]      ge, hit;
  logic signed [ValueW-1:0] vals [CAPACITY];

  assign accept = in_valid_i && in_ready_o;
  assign commit = busy_q && (!out_valid_q || out_ready_i);
  assign full   = count_q == CntW'(CAPACITY);
  assign empty  = count_q == '0;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic                     prev_ge;
    logic signed [ValueW-1:0] prev_val, next_val;

    if (j == 0) begin : g_head
      assign prev_ge  = 1'b0;
      assign prev_val = '0;
    end else begin : g_body
      assign prev_ge  = ge[j-1];
      assign prev_val = vals[j-1];
    end
    if (j == CAPACITY - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_link
      assign next_val = vals[j+1];
    end

    sst_cell u_cell (
      .clk_i      (clk_i),
      .capture_i  (accept),
      .cmp_key_i  (value_i),
      .valid_i    (count_q > CntW'(j)),
      .ctrl_i     (ctrl),
      .prev_ge_i  (prev_ge),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .ge_o       (ge[j]),
      .hit_o      (hit[j]),
      .val_o      (vals[j])
    );
  end

  sst_encoder #(
    .Depth (CAPACITY),
    .IdxW  (IdxW)
  ) u_encoder (
    .hit_i   (hit),
    .idx_o   (hit_idx),
    .found_o (found)
  );

  always_comb begin
    ctrl       = '0;
    ctrl.key   = key_q;
    count_d    = count_q;
    status_d   = ST_OK;
    position_d = '0;
    idx_ext    = {{PosW{1'b0}}, hit_idx};
    case (cmd_q)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = commit;
          count_d  = count_q + CntW'(1);
        end
      end
      CMD_DELETE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (found) begin
          ctrl.del = commit;
          count_d  = count_q - CntW'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      CMD_FIND: begin
        if (found) begin
          position_d = idx_ext[PosW-1:0];
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    cnt_ext = {{CountW{1'b0}}, count_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (commit) begin
        busy_q <= 1'b0;
      end
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the command until the commit cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      key_q <= value_i;
    end
    if (commit) begin
      status_q    <= status_d;
      position_q  <= position_d;
      res_count_q <= cnt_ext[CountW-1:0];
    end
  end

  assign in_ready_o  = !busy_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = position_q;
  assign count_o     = res_count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_single_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> $onehot0(hit))
    else $error("more than one cell reports the first match");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && cmd_q == CMD_INSERT && !full) |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the table");

  a_result_from_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("result shown without a transaction in flight");

endmodule

// ----- tb/sv/tb_sorted_set_table.sv -----
`timescale 1ns / 1ps

module tb_sorted_set_table;
  import sst_pkg::*;

  localparam int unsigned Capacity = 32;
  localparam logic [1:0]  CmdUnused = 2'd3;
  localparam int unsigned DrainLimit = 20000;

  typedef struct packed {
    logic [1:0]        status;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               cmd_drv = CMD_INSERT;
  logic signed [ValueW-1:0] value_drv = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic [PosW-1:0]          position;
  logic [CountW-1:0]        count;

  // Shadow copy of the table, updated as each input transaction is accepted
  logic signed [ValueW-1:0] shadow_vals [Capacity];
  int unsigned              shadow_count = 0;

  table_result_t expected_outcomes [$];
  int unsigned   mismatch_count = 0;
  bit            no_gaps = 1'b0;
  int unsigned   out_hold = 0;

  sorted_set_table #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .cmd_i      (cmd_drv),
    .value_i    (value_drv),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .status_o   (status),
    .position_o (position),
    .count_o    (count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Apply one command to the shadow table and return the result it should give
  function automatic table_result_t table_outcome(input logic [1:0] cmd,
                                                  input logic signed [ValueW-1:0] value);
    table_result_t res;
    int unsigned   idx;
    res = '0;
    idx = shadow_count;
    for (int unsigned j = 0; j < shadow_count; j++) begin
      if (shadow_vals[j] >= value) begin
        idx = j;
        break;
      end
    end
    case (cmd)
      CMD_INSERT: begin
        if (shadow_count >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          for (int unsigned j = shadow_count; j > idx; j--) shadow_vals[j] = shadow_vals[j-1];
          shadow_vals[idx] = value;
          shadow_count++;
        end
      end
      CMD_DELETE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (idx < shadow_count && shadow_vals[idx] == value) begin
          for (int unsigned j = idx; j + 1 < shadow_count; j++) shadow_vals[j] = shadow_vals[j+1];
          shadow_count--;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      CMD_FIND: begin
        if (idx < shadow_count && shadow_vals[idx] == value) res.position = idx[PosW-1:0];
        else res.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    res.count = shadow_count[CountW-1:0];
    return res;
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40 && shadow_count != 0) return shadow_vals[$urandom_range(0, shadow_count - 1)];
    if (r < 60) return $urandom_range(0, 8) - 4;
    if (r < 70) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh8000_0001;
        2: return 32'sh7fff_ffff;
        3: return 32'sh7fff_fffe;
        4: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  // Present one command and hold it until the transaction completes
  task automatic send_command(input logic [1:0] cmd, input logic signed [ValueW-1:0] value);
    int unsigned gap;
    gap = gap_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd_drv   <= cmd;
    value_drv <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_outcomes.push_back(table_outcome(cmd, value));
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result, status", status, -1);
      end else begin
        want = expected_outcomes.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (position !== want.position) report_mismatch("position", position, want.position);
        if (count !== want.count) report_mismatch("count", count, want.count);
      end
    end
    if (out_hold != 0) begin
      out_ready <= 1'b0;
      out_hold = out_hold - 1;
    end else begin
      out_ready <= 1'b1;
      out_hold = gap_length();
    end
  end

  task automatic test_directed();
    no_gaps = 1'b0;
    send_command(CMD_FIND, 32'sd0);
    send_command(CMD_DELETE, 32'sd5);
    send_command(CmdUnused, 32'sd0);
    send_command(CMD_INSERT, 32'sd0);
    send_command(CMD_INSERT, 32'sh8000_0000);
    send_command(CMD_INSERT, 32'sh7fff_ffff);
    send_command(CMD_INSERT, -32'sd1);
    send_command(CMD_INSERT, 32'sd0);
    send_command(CMD_INSERT, 32'sd0);
    send_command(CMD_INSERT, 32'sd1);
    send_command(CMD_FIND, 32'sd0);
    send_command(CMD_FIND, 32'sh8000_0000);
    send_command(CMD_FIND, 32'sh7fff_ffff);
    send_command(CMD_FIND, 32'sd7);
    send_command(CMD_DELETE, 32'sd7);
    send_command(CMD_DELETE, 32'sd0);
    send_command(CMD_FIND, 32'sd0);
    send_command(CmdUnused, -32'sd1);
    send_command(CMD_DELETE, 32'sh8000_0000);
    send_command(CMD_DELETE, 32'sh7fff_ffff);
    send_command(CMD_FIND, -32'sd1);
    send_command(CMD_INSERT, 32'sh5555_5555);
    send_command(CMD_INSERT, 32'shaaaa_aaaa);
    send_command(CMD_DELETE, -32'sd1);
  endtask

  task automatic test_fill_and_drain();
    no_gaps = 1'b0;
    while (shadow_count < Capacity) send_command(CMD_INSERT, pick_value());
    send_command(CMD_INSERT, 32'sh8000_0000);
    send_command(CMD_INSERT, 32'sh7fff_ffff);
    send_command(CMD_INSERT, pick_value());
    repeat (6) send_command(CMD_FIND, pick_value());
    send_command(CMD_FIND, shadow_vals[Capacity-1]);
    no_gaps = 1'b1;
    while (shadow_count != 0) send_command(CMD_DELETE, shadow_vals[$urandom_range(0, shadow_count - 1)]);
    no_gaps = 1'b0;
    send_command(CMD_DELETE, pick_value());
    send_command(CMD_FIND, pick_value());
  endtask

  task automatic test_random_mix();
    int unsigned r;
    int unsigned insert_pct;
    logic [1:0]  cmd;
    for (int seg = 0; seg < 8; seg++) begin
      // Alternate growing and shrinking phases so the count sweeps its range
      insert_pct = (seg % 2 == 0) ? 65 : 25;
      no_gaps = (seg % 4 == 3);
      repeat (32) begin
        r = $urandom_range(0, 99);
        if (r < 4) cmd = CmdUnused;
        else if (r < 4 + insert_pct) cmd = CMD_INSERT;
        else if (r < 4 + insert_pct + (96 - insert_pct) / 2) cmd = CMD_DELETE;
        else cmd = CMD_FIND;
        send_command(cmd, pick_value());
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    int unsigned drain;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_and_drain();
    test_random_mix();
    test_fill_and_drain();
    in_valid <= 1'b0;
    drain = 0;
    while (expected_outcomes.size() != 0 && drain < DrainLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (expected_outcomes.size() != 0)
      report_mismatch("results never delivered", 0, expected_outcomes.size());
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
